// ===== rtl/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants for the triangle unit normal block
// Payload structs, datapath widths and the side band carried past the root.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int CW         = 24;           // vertex coordinate width
	localparam int EW         = CW + 1;       // edge width
	localparam int PW         = 2 * EW;       // product / cross component width
	localparam int MW         = PW - 1;       // cross component magnitude width
	localparam int LW         = 32;           // low part of a magnitude
	localparam int HW         = MW - LW;      // high part of a magnitude
	localparam int QSW        = 2 * MW;       // one squared component
	localparam int SW         = QSW + 2;      // sum of three squares
	localparam int RW         = 51;           // square root width
	localparam int XW         = 2 * RW;       // radicand width seen by the root
	localparam int UNIT_SHIFT = 14;           // Q1.14 scale
	localparam int QW         = UNIT_SHIFT + 1;
	localparam int OW         = 16;           // output component width
	localparam int NCOMP      = 3;

	typedef struct packed {
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic signed [CW-1:0] a_z;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic signed [CW-1:0] b_z;
		logic signed [CW-1:0] c_x;
		logic signed [CW-1:0] c_y;
		logic signed [CW-1:0] c_z;
	} in_t;

	typedef struct packed {
		logic signed [OW-1:0] normal_x;
		logic signed [OW-1:0] normal_y;
		logic signed [OW-1:0] normal_z;
		logic                 degenerate;
	} out_t;

	typedef struct packed {
		logic [NCOMP-1:0][MW-1:0] mag;
		logic [NCOMP-1:0]         neg;
		logic                     degen;
	} side_t;

endpackage

// ===== rtl/tun_sqrt.sv =====
// ----------------------------------------------------------------------------
// tun_sqrt: pipelined integer square root
// One result bit per stage, restoring digit-by-digit method, side band follows.
// ----------------------------------------------------------------------------
module tun_sqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [tun_pkg::XW-1:0] x,
	input  tun_pkg::side_t        side_in,
	output logic                  out_vld,
	output logic [tun_pkg::RW-1:0] root,
	output tun_pkg::side_t        side_out
);
	import tun_pkg::*;

	localparam int RMW = RW + 3;

	logic           vld_s  [RW];
	logic [RMW-1:0] rem_s  [RW];
	logic [RW-1:0]  root_s [RW];
	logic [XW-1:0]  x_s    [RW];
	side_t          side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic           pv;
		logic [RMW-1:0] prem;
		logic [RW-1:0]  proot;
		logic [XW-1:0]  px;
		side_t          pside;
		logic [RMW-1:0] cur;
		logic [RMW-1:0] trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign pv    = in_vld;
			assign prem  = '0;
			assign proot = '0;
			assign px    = x;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign px    = x_s[k-1];
			assign pside = side_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {prem[RMW-3:0], px[XW-1-2*k -: 2]};
		assign trial = RMW'({proot, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (cur - trial) : cur;
				root_s[k] <= {proot[RW-2:0], ge};
				x_s[k]    <= px;
				side_s[k] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign side_out = side_s[RW-1];

endmodule

// ===== rtl/tun_div.sv =====
// ----------------------------------------------------------------------------
// tun_div: pipelined scale-and-divide for three lanes
// Restoring division, one quotient bit per stage, sign and zero case at the end.
// ----------------------------------------------------------------------------
module tun_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [tun_pkg::RW-1:0] divisor,
	input  tun_pkg::side_t        side_in,
	output logic                  out_vld,
	output tun_pkg::out_t         out_data
);
	import tun_pkg::*;

	logic                         vld_s  [QW];
	logic [NCOMP-1:0][RW-1:0]     rem_s  [QW];
	logic [NCOMP-1:0][QW-1:0]     q_s    [QW];
	logic [RW-1:0]                d_s    [QW];
	side_t                        side_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic                     pv;
		logic [NCOMP-1:0][RW-1:0] prem;
		logic [NCOMP-1:0][QW-1:0] pq;
		logic [RW-1:0]            pd;
		side_t                    pside;
		logic [NCOMP-1:0]         pbit;
		logic [NCOMP-1:0][RW-1:0] nrem;
		logic [NCOMP-1:0][QW-1:0] nq;

		if (j == 0) begin : g_first
			// dividend is mag << 14; the top part mag >> 1 is already below s
			assign pv    = in_vld;
			assign pd    = divisor;
			assign pside = side_in;
			assign pq    = '0;
			for (genvar l = 0; l < NCOMP; l++) begin : g_lane
				assign prem[l] = RW'(side_in.mag[l] >> 1);
				assign pbit[l] = side_in.mag[l][0];
			end
		end else begin : g_next
			assign pv    = vld_s[j-1];
			assign pd    = d_s[j-1];
			assign pside = side_s[j-1];
			assign pq    = q_s[j-1];
			assign prem  = rem_s[j-1];
			assign pbit  = '0;
		end

		always_comb begin
			logic [RW:0] cur;
			logic [RW:0] dif;
			for (int l = 0; l < NCOMP; l++) begin
				cur = {prem[l], pbit[l]};
				dif = cur - {1'b0, pd};
				if (cur >= {1'b0, pd}) begin
					nrem[l] = dif[RW-1:0];
					nq[l]   = {pq[l][QW-2:0], 1'b1};
				end else begin
					nrem[l] = cur[RW-1:0];
					nq[l]   = {pq[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= nrem;
				q_s[j]    <= nq;
				d_s[j]    <= pd;
				side_s[j] <= pside;
			end
		end
	end

	// restore sign, force zero on a degenerate triangle
	logic [NCOMP-1:0][OW-1:0] comp;

	always_comb begin
		for (int l = 0; l < NCOMP; l++) begin
			if (side_s[QW-1].degen) begin
				comp[l] = '0;
			end else if (side_s[QW-1].neg[l]) begin
				comp[l] = OW'(-OW'(q_s[QW-1][l]));
			end else begin
				comp[l] = OW'(q_s[QW-1][l]);
			end
		end
	end

	assign out_vld             = vld_s[QW-1];
	assign out_data.normal_x   = comp[0];
	assign out_data.normal_y   = comp[1];
	assign out_data.normal_z   = comp[2];
	assign out_data.degenerate = side_s[QW-1].degen;

endmodule

// ===== rtl/triangle_unit_normal_top.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal_top: unit face normal of one triangle per transfer
// Edges, cross product, squared length, square root and Q1.14 scaling.
// ----------------------------------------------------------------------------
// Takes one triangle (three Q12.12 vertices) per clock unless stalled and
// returns its unit normal in Q1.14, rounded toward zero, with a flag for a
// zero-area triangle (normal forced to zero). Throughput is one transfer per
// cycle when not stalled. The path is 7 front stages (edges, cross products,
// cross components, magnitudes, partial products, squares, sum), 51 square
// root stages (one root bit each) and 15 division stages (one quotient bit
// each). The whole pipeline advances together: when a result waits on
// out_ready every stage holds, and in_ready stays low while it waits.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tun_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tun_pkg::out_t  out_data
);
	import tun_pkg::*;

	// advance when the output slot is empty or being drained
	logic en;
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	// valid bits of the front stages
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: edges E1 = B - A, E2 = C - A, exact in 25 bits
	logic signed [EW-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= EW'(in_data.b_x) - EW'(in_data.a_x);
			e1y_s1 <= EW'(in_data.b_y) - EW'(in_data.a_y);
			e1z_s1 <= EW'(in_data.b_z) - EW'(in_data.a_z);
			e2x_s1 <= EW'(in_data.c_x) - EW'(in_data.a_x);
			e2y_s1 <= EW'(in_data.c_y) - EW'(in_data.a_y);
			e2z_s1 <= EW'(in_data.c_z) - EW'(in_data.a_z);
		end
	end

	// stage 2: the six 25x25 products of the cross product
	logic signed [PW-1:0] pyz_s2, pzy_s2, pzx_s2, pxz_s2, pxy_s2, pyx_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pyz_s2 <= e1y_s1 * e2z_s1;
			pzy_s2 <= e1z_s1 * e2y_s1;
			pzx_s2 <= e1z_s1 * e2x_s1;
			pxz_s2 <= e1x_s1 * e2z_s1;
			pxy_s2 <= e1x_s1 * e2y_s1;
			pyx_s2 <= e1y_s1 * e2x_s1;
		end
	end

	// stage 3: cross components
	logic signed [PW-1:0] n_s3 [NCOMP];

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3[0] <= pyz_s2 - pzy_s2;
			n_s3[1] <= pzx_s2 - pxz_s2;
			n_s3[2] <= pxy_s2 - pyx_s2;
		end
	end

	// stage 4: magnitudes, signs and the zero-vector flag
	side_t side_s4;
	side_t side_c4;

	always_comb begin
		logic [PW-1:0] t;
		for (int l = 0; l < NCOMP; l++) begin
			t               = n_s3[l][PW-1] ? PW'(-n_s3[l]) : PW'(n_s3[l]);
			side_c4.mag[l]  = t[MW-1:0];
			side_c4.neg[l]  = n_s3[l][PW-1];
		end
		side_c4.degen = (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_c4;
		end
	end

	// stage 5: partial products of each square, split at bit 32
	logic [2*HW-1:0]   hh_s5 [NCOMP];
	logic [HW+LW-1:0]  hl_s5 [NCOMP];
	logic [2*LW-1:0]   ll_s5 [NCOMP];
	side_t             side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NCOMP; l++) begin
				hh_s5[l] <= side_s4.mag[l][MW-1:LW] * side_s4.mag[l][MW-1:LW];
				hl_s5[l] <= side_s4.mag[l][MW-1:LW] * side_s4.mag[l][LW-1:0];
				ll_s5[l] <= side_s4.mag[l][LW-1:0] * side_s4.mag[l][LW-1:0];
			end
			side_s5 <= side_s4;
		end
	end

	// stage 6: each square = hh<<64 + 2*hl<<32 + ll
	logic [QSW-1:0] sq_s6 [NCOMP];
	side_t          side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NCOMP; l++) begin
				sq_s6[l] <= (QSW'(hh_s5[l]) << (2 * LW)) + (QSW'(hl_s5[l]) << (LW + 1))
					+ QSW'(ll_s5[l]);
			end
			side_s6 <= side_s5;
		end
	end

	// stage 7: squared length, exact in 100 bits
	logic [SW-1:0] sum_s7;
	side_t         side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			side_s7 <= side_s6;
		end
	end

	// root and division pipelines
	logic          vld_r;
	logic [RW-1:0] root_r;
	side_t         side_r;

	tun_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s7),
		.x        (XW'(sum_s7)),
		.side_in  (side_s7),
		.out_vld  (vld_r),
		.root     (root_r),
		.side_out (side_r)
	);

	tun_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_r),
		.divisor  (root_r),
		.side_in  (side_r),
		.out_vld  (out_valid),
		.out_data (out_data)
	);

	// a flagged triangle carries a zero normal
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |->
			out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0)
		else $error("degenerate result with nonzero normal");

	// a real normal never has all components zero
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.degenerate |->
			out_data.normal_x != 0 || out_data.normal_y != 0 || out_data.normal_z != 0)
		else $error("non-degenerate result with zero normal");

	// components stay within one unit
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			$signed(out_data.normal_x) <= 16384 && $signed(out_data.normal_x) >= -16384 &&
			$signed(out_data.normal_y) <= 16384 && $signed(out_data.normal_y) >= -16384 &&
			$signed(out_data.normal_z) <= 16384 && $signed(out_data.normal_z) >= -16384)
		else $error("normal component out of range");

endmodule
